[rtl/core/wsd_pkg.sv]
package wsd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 3;
  localparam int unsigned LenW   = 63;
  localparam int unsigned TdataW = 72;
  localparam int unsigned TuserW = 5;

  typedef struct packed {
    logic [LenW-1:0]  frame_length;
    logic             end_of_frame;
    logic             fin_flag;
    logic [KindW-1:0] frame_kind;
    logic             has_data;
    logic [ByteW-1:0] data_byte;
  } result_t;

endpackage

[rtl/core/wsd_in_reg.sv]
module wsd_in_reg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [wsd_pkg::ByteW-1:0] s_tdata,
  input  logic                      advance,
  output logic                      in_valid,
  output logic [wsd_pkg::ByteW-1:0] in_byte
);
  import wsd_pkg::*;

  logic accept;

  assign s_tready = !in_valid || advance;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= s_tdata;
    end
  end

endmodule

[rtl/core/wsd_parser.sv]
module wsd_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic [wsd_pkg::ByteW-1:0] in_byte,
  output logic                      res_valid,
  output wsd_pkg::result_t          res
);
  import wsd_pkg::*;

  localparam logic [2:0] PH_HDR0  = 3'd0;
  localparam logic [2:0] PH_HDR1  = 3'd1;
  localparam logic [2:0] PH_EXT16 = 3'd2;
  localparam logic [2:0] PH_EXT64 = 3'd3;
  localparam logic [2:0] PH_MASK  = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [KindW-1:0] KIND_UNKNOWN = 3'd0;
  localparam logic [KindW-1:0] KIND_TEXT    = 3'd1;
  localparam logic [KindW-1:0] KIND_BINARY  = 3'd2;
  localparam logic [KindW-1:0] KIND_CLOSE   = 3'd3;
  localparam logic [KindW-1:0] KIND_PING    = 3'd4;
  localparam logic [KindW-1:0] KIND_PONG    = 3'd5;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  logic [2:0]       phase, phase_next;
  logic [2:0]       count, count_next;
  logic [KindW-1:0] kind, kind_next;
  logic             fin, fin_next;
  logic             masked, masked_next;
  logic [31:0]      key_word, key_word_next;
  logic [LenW-1:0]  length, length_next;
  logic [LenW-1:0]  remaining, remaining_next;

  logic             done_len, done_hdr;
  logic [LenW-1:0]  done_val, hdr_len, len_shift, rem_dec;
  logic [1:0]       offset;
  logic [ByteW-1:0] key_byte;
  logic [2:0]       ext_last;

  function automatic logic [KindW-1:0] kind_of(input logic [3:0] op);
    logic [KindW-1:0] k;
    case (op)
      OP_TEXT:   k = KIND_TEXT;
      OP_BINARY: k = KIND_BINARY;
      OP_CLOSE:  k = KIND_CLOSE;
      OP_PING:   k = KIND_PING;
      OP_PONG:   k = KIND_PONG;
      default:   k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  assign len_shift = {length[LenW-ByteW-1:0], in_byte};
  assign rem_dec   = remaining - LenW'(1);
  assign offset    = length[1:0] - remaining[1:0];
  assign ext_last  = (phase == PH_EXT16) ? 3'd1 : 3'd7;

  always_comb begin
    case (offset)
      2'd0:    key_byte = key_word[31:24];
      2'd1:    key_byte = key_word[23:16];
      2'd2:    key_byte = key_word[15:8];
      default: key_byte = key_word[7:0];
    endcase
  end

  always_comb begin
    phase_next     = phase;
    count_next     = count;
    kind_next      = kind;
    fin_next       = fin;
    masked_next    = masked;
    key_word_next  = key_word;
    length_next    = length;
    remaining_next = remaining;
    done_len       = 1'b0;
    done_hdr       = 1'b0;
    done_val       = length;
    res_valid      = 1'b0;
    res            = '0;

    case (phase)
      PH_HDR0: begin
        fin_next   = in_byte[7];
        kind_next  = kind_of(in_byte[3:0]);
        phase_next = PH_HDR1;
      end
      PH_HDR1: begin
        masked_next = in_byte[7];
        count_next  = 3'd0;
        length_next = '0;
        if (in_byte[6:0] == LEN_EXT16) begin
          phase_next = PH_EXT16;
        end else if (in_byte[6:0] == LEN_EXT64) begin
          phase_next = PH_EXT64;
        end else begin
          done_len = 1'b1;
          done_val = LenW'(in_byte[6:0]);
        end
      end
      PH_EXT16, PH_EXT64: begin
        length_next = len_shift;
        if (count >= ext_last) begin
          done_len = 1'b1;
          done_val = len_shift;
        end else begin
          count_next = count + 3'd1;
        end
      end
      PH_MASK: begin
        key_word_next = {key_word[23:0], in_byte};
        if (count >= 3'd3) begin
          done_hdr = 1'b1;
        end else begin
          count_next = count + 3'd1;
        end
      end
      PH_DATA: begin
        remaining_next   = rem_dec;
        res_valid        = 1'b1;
        res.data_byte    = masked ? (in_byte ^ key_byte) : in_byte;
        res.has_data     = 1'b1;
        res.frame_kind   = kind;
        res.fin_flag     = fin;
        res.end_of_frame = (rem_dec == '0);
        res.frame_length = length;
        if (rem_dec == '0) begin
          phase_next = PH_HDR0;
          count_next = 3'd0;
        end
      end
      default: begin
        phase_next = PH_HDR0;
        count_next = 3'd0;
      end
    endcase

    if (done_len) begin
      length_next = done_val;
      count_next  = 3'd0;
      if (masked_next) begin
        key_word_next = '0;
        phase_next    = PH_MASK;
      end else begin
        done_hdr = 1'b1;
      end
    end

    hdr_len = done_len ? done_val : length;

    if (done_hdr) begin
      count_next = 3'd0;
      if (hdr_len == '0) begin
        res_valid        = 1'b1;
        res.frame_kind   = kind_next;
        res.fin_flag     = fin_next;
        res.end_of_frame = 1'b1;
        phase_next       = PH_HDR0;
      end else begin
        remaining_next = hdr_len;
        phase_next     = PH_DATA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR0;
      count     <= 3'd0;
      kind      <= KIND_UNKNOWN;
      fin       <= 1'b0;
      masked    <= 1'b0;
      key_word  <= '0;
      length    <= '0;
      remaining <= '0;
    end else if (advance) begin
      phase     <= phase_next;
      count     <= count_next;
      kind      <= kind_next;
      fin       <= fin_next;
      masked    <= masked_next;
      key_word  <= key_word_next;
      length    <= length_next;
      remaining <= remaining_next;
    end
  end

  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.has_data |-> res.end_of_frame && res.frame_length == '0)
    else $error("empty-frame marker not marked as last");

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    phase <= PH_DATA)
    else $error("parse phase out of range");

  a_eof_returns: assert property (@(posedge clk) disable iff (rst)
    advance && res_valid && res.end_of_frame |=> phase == PH_HDR0)
    else $error("frame end did not return to header parsing");

  a_data_nonzero_left: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> remaining != '0)
    else $error("payload phase with nothing remaining");

endmodule

[rtl/core/wsd_out_reg.sv]
module wsd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  wsd_pkg::result_t res,
  output logic             out_free,
  output logic             m_tvalid,
  input  logic             m_tready,
  output wsd_pkg::result_t out_res
);
  import wsd_pkg::*;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

[rtl/core/websocket_frame_deframer_unit.sv]
// WebSocket receive-side deframer.
// Slave channel: one received byte per item on s_tdata.
// Master channel: one item per payload byte, or one empty-frame marker for a
// zero-length frame; m_tlast marks the last item of each frame.
// Header bytes (base header, extended length, mask key) produce no item.
// Payload bytes of masked frames leave unmasked with key byte (offset mod 4).
// Path: an accepted byte is registered in the input register, parsed, and its
// result is registered in the output register that drives the master side.
// Throughput: one byte per cycle while the master side takes items; the input
// register then advances every cycle and the result register loads each item.
// Stall: while m_tready is low and a result is held, the parse stage stops
// and s_tready drops once its input register is full.
// Reset (rst, synchronous): clears both stage valids and returns the parser
// to expecting the first header byte of a new frame.
module websocket_frame_deframer_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [wsd_pkg::ByteW-1:0]  s_tdata,  // [7:0] rx_byte
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [wsd_pkg::TdataW-1:0] m_tdata,  // [7:0] data_byte, [70:8] frame_length
  output logic [wsd_pkg::TuserW-1:0] m_tuser,  // [0] has_data, [3:1] frame_kind, [4] fin_flag
  output logic                       m_tlast   // end_of_frame
);
  import wsd_pkg::*;

  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             advance;
  logic             out_free;
  logic             res_valid;
  result_t          res;
  result_t          out_res;

  assign advance = in_valid && out_free;

  wsd_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .advance  (advance),
    .in_valid (in_valid),
    .in_byte  (in_byte)
  );

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res_valid),
    .res      (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .out_res  (out_res)
  );

  assign m_tdata = {1'b0, out_res.frame_length, out_res.data_byte};
  assign m_tuser = {out_res.fin_flag, out_res.frame_kind, out_res.has_data};
  assign m_tlast = out_res.end_of_frame;

endmodule
